// File: sv/ohp_pkg.sv
// Shared types and constants of the on-CPU time log2 histogram block.
package ohp_pkg;

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned ID_W       = 15;
  localparam int unsigned NOW_W      = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SLOT_FW    = 4;
  localparam int unsigned BIN_FW     = 5;
  localparam int unsigned STAT_W     = 2;

  // Lowest elapsed time, in nanoseconds, that lands in bin one.
  localparam logic [NOW_W:0] FIRST_THRESHOLD = 65'd2000000;

  localparam logic [STAT_W-1:0] ST_NONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_INC  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_READ = 2'd3;

  localparam logic KIND_SWITCH = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_LOG,
    S_BRD,
    S_INC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic idle;
    logic clear;
    logic accept;
    logic lookup;
    logic step;
    logic brd;
    logic inc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_read;
    logic record;
    logic full;
    logic log_more;
    logic out_free;
  } sts_t;

endpackage

// File: sv/ohp_ctrl.sv
// Sequencer of the histogram block: clearing pass, lookup, log search and update.
module ohp_ctrl
  import ohp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:   if (s_tvalid) state_next = S_LOOKUP;
      S_LOOKUP: begin
        if (sts.is_read || !sts.record || sts.full) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_LOG;
        end
      end
      S_LOG:    if (!sts.log_more) state_next = S_BRD;
      S_BRD:    state_next = S_INC;
      S_INC:    state_next = S_EMIT;
      S_EMIT:   if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.idle   = (state == S_IDLE);
    cmd.clear  = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && s_tvalid;
    cmd.lookup = (state == S_LOOKUP);
    cmd.step   = (state == S_LOG);
    cmd.brd    = (state == S_BRD);
    cmd.inc    = (state == S_INC);
    cmd.emit   = (state == S_EMIT);
  end

endmodule

// File: sv/ohp_dp.sv
// Datapath: start-time and bin memories, group table, log search and output register.
module ohp_dp
  import ohp_pkg::*;
#(
  parameter int unsigned TASK_ID_BITS  = 15,
  parameter int unsigned GROUP_ENTRIES = 16,
  parameter int unsigned BIN_COUNT     = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_valid,
  input  logic [ID_W-1:0]       cfg_data,
  input  logic                  s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [STAT_W-1:0]     m_tuser,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned SW  = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
  localparam int unsigned BW  = $clog2(BIN_COUNT);
  localparam int unsigned AW  = SW + BW;
  localparam int unsigned CW  = (TASK_ID_BITS > AW) ? TASK_ID_BITS : AW;
  localparam int unsigned TW  = (TASK_ID_BITS > ID_W) ? TASK_ID_BITS : ID_W;
  localparam int unsigned TDEPTH = 1 << TASK_ID_BITS;
  localparam int unsigned BDEPTH = 1 << AW;

  // Input fields.
  logic [ID_W-1:0]  in_group, in_task, in_parent, out_group, out_task, out_parent;
  logic [NOW_W-1:0] now_ns;
  logic [8:0]       rs9;
  logic [6:0]       rb7;
  logic [TW-1:0]    it_w, ot_w;
  logic [TASK_ID_BITS-1:0] it_idx, ot_idx;

  assign in_group   = s_tdata[14:0];
  assign in_task    = s_tdata[29:15];
  assign in_parent  = s_tdata[44:30];
  assign out_group  = s_tdata[59:45];
  assign out_task   = s_tdata[74:60];
  assign out_parent = s_tdata[89:75];
  assign now_ns     = s_tdata[153:90];
  assign rs9        = 9'(s_tdata[157:154]);
  assign rb7        = 7'(s_tdata[162:158]);
  assign it_w       = TW'(in_task);
  assign ot_w       = TW'(out_task);
  assign it_idx     = it_w[TASK_ID_BITS-1:0];
  assign ot_idx     = ot_w[TASK_ID_BITS-1:0];

  logic [ID_W-1:0] target;
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_valid) begin
      target <= cfg_data;
    end
  end

  logic in_q, out_q;
  assign in_q  = (target != '0) && ((in_group == target) || (in_parent == target));
  assign out_q = (target != '0) && ((out_group == target) || (out_parent == target));

  // Captured item.
  logic             kind_r, oq_r;
  logic [ID_W-1:0]  og_r;
  logic [NOW_W-1:0] now_r;
  logic [8:0]       rs_r;
  logic [6:0]       rb_r;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= s_tuser;
      // A task switched in and out at once has its start overwritten with now.
      oq_r   <= out_q && !(in_q && (it_idx == ot_idx));
      og_r   <= out_group;
      now_r  <= now_ns;
      rs_r   <= rs9;
      rb_r   <= rb7;
    end
  end

  // Clearing pass counter.
  logic [CW-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Start-time memory: valid bit over 64-bit time.
  logic [NOW_W:0] start_mem [TDEPTH];
  logic [NOW_W:0] st_rd;
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      start_mem[clr_cnt[TASK_ID_BITS-1:0]] <= '0;
    end else if (cmd.accept && (s_tuser == KIND_SWITCH) && in_q) begin
      start_mem[it_idx] <= {1'b1, now_ns};
    end
    if (cmd.accept) begin
      st_rd <= start_mem[ot_idx];
    end
  end

  // Group table.
  logic [ID_W-1:0]          gtag   [GROUP_ENTRIES];
  logic [GROUP_ENTRIES-1:0] gvalid;
  logic                     hit, has_free;
  logic [SW-1:0]            hit_idx, free_idx;
  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = GROUP_ENTRIES - 1; i >= 0; i--) begin
      if (gvalid[i] && (gtag[i] == og_r)) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!gvalid[i]) begin
        has_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // Log search and bin memory.
  logic [NOW_W-1:0] diff;
  logic [NOW_W:0]   thr;
  logic [BW-1:0]    bsel;
  logic [SW-1:0]    slot_r;
  logic             alloc_r;
  logic [CNT_W-1:0] bin_mem [BDEPTH];
  logic [CNT_W-1:0] bin_rd;
  logic [CNT_W-1:0] bin_inc;
  logic [AW-1:0]    upd_addr;

  assign upd_addr = {slot_r, bsel};
  assign bin_inc  = bin_rd + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      bin_mem[clr_cnt[AW-1:0]] <= '0;
    end else if (cmd.inc) begin
      bin_mem[upd_addr] <= bin_inc;
    end
    if (cmd.accept) begin
      bin_rd <= bin_mem[{rs9[SW-1:0], rb7[BW-1:0]}];
    end else if (cmd.brd) begin
      bin_rd <= bin_mem[upd_addr];
    end
  end

  logic record, read_live;
  assign record    = oq_r && st_rd[NOW_W] && (now_r > st_rd[NOW_W-1:0]);
  assign read_live = (rs_r < 9'(GROUP_ENTRIES)) && gvalid[rs_r[SW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      diff    <= now_r - st_rd[NOW_W-1:0];
      thr     <= FIRST_THRESHOLD;
      bsel    <= '0;
      slot_r  <= hit ? hit_idx : free_idx;
      alloc_r <= !hit;
    end else if (cmd.step && sts.log_more) begin
      bsel <= bsel + 1'b1;
      thr  <= {thr[NOW_W-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= '0;
    end else if (cmd.inc && alloc_r) begin
      gvalid[slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.inc && alloc_r) begin
      gtag[slot_r] <= og_r;
    end
  end

  // Pending result.
  logic [STAT_W-1:0]  r_status;
  logic [SLOT_FW-1:0] r_slot;
  logic [ID_W-1:0]    r_gid;
  logic               r_live;
  logic [BIN_FW-1:0]  r_bin;
  logic [CNT_W-1:0]   r_cnt;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      r_status <= ST_NONE;
      r_slot   <= '0;
      r_gid    <= '0;
      r_live   <= 1'b0;
      r_bin    <= '0;
      r_cnt    <= '0;
      if (kind_r == KIND_READ) begin
        r_status <= ST_READ;
        r_slot   <= rs_r[SLOT_FW-1:0];
        r_bin    <= rb_r[BIN_FW-1:0];
        if (read_live) begin
          r_live <= 1'b1;
          r_gid  <= gtag[rs_r[SW-1:0]];
          r_cnt  <= (rb_r < 7'(BIN_COUNT)) ? bin_rd : '0;
        end
      end else if (record && !hit && !has_free) begin
        r_status <= ST_FULL;
        r_gid    <= og_r;
      end
    end else if (cmd.inc) begin
      r_status <= ST_INC;
      r_slot   <= SLOT_FW'(slot_r);
      r_gid    <= og_r;
      r_live   <= 1'b1;
      r_bin    <= BIN_FW'(bsel);
      r_cnt    <= bin_inc;
    end
  end

  // Output register.
  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      m_tuser <= r_status;
      m_tdata <= {7'd0, r_cnt, r_bin, r_live, r_gid, r_slot};
    end
  end

  always_comb begin
    sts          = '0;
    sts.clr_done = &clr_cnt;
    sts.is_read  = (kind_r == KIND_READ);
    sts.record   = record;
    sts.full     = !hit && !has_free;
    sts.log_more = ({1'b0, diff} >= thr) && (bsel != BW'(BIN_COUNT - 1));
    sts.out_free = out_free;
  end

endmodule

// File: sv/oncpu_time_log2_histogram.sv
// Top level of the on-CPU time log2 histogram: sequencer, datapath and checks.
//
//   channel  direction  handshake             contents
//   cfg      in         cfg_valid/cfg_ready   target_group
//   s        in         s_tvalid/s_tready     one task-switch or read word
//   m        out        m_tvalid/m_tready     one result word per input word
//
// After reset a clearing pass steps a max(TASK_ID_BITS, log2 slots + log2 bins)-bit
// counter through every address and zeroes both memories; no input word is taken
// meanwhile. A read word or an event that records nothing passes through lookup and
// emit; an event that records also runs the log search, which tests one doubling
// millisecond threshold per cycle against the elapsed time, then a bin read and an
// increment. One word is in flight at a time; a waiting result stalls only emit.
module oncpu_time_log2_histogram
  import ohp_pkg::*;
#(
  parameter int unsigned TASK_ID_BITS  = 15,
  parameter int unsigned GROUP_ENTRIES = 16,
  parameter int unsigned BIN_COUNT     = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ID_W-1:0]       cfg_data,   // target_group
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tuser,    // kind
  // in_group, in_task, in_parent, out_group, out_task, out_parent, now_ns,
  // read_slot, read_bin, then zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [STAT_W-1:0]     m_tuser,    // status
  // group_slot, group_id, group_live, bin, count, then zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cmd_t cmd;
  sts_t sts;

  // The register may be written at any time; it is only sampled by events.
  assign cfg_ready = 1'b1;
  assign s_tready  = cmd.idle;

  ohp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  ohp_dp #(
    .TASK_ID_BITS  (TASK_ID_BITS),
    .GROUP_ENTRIES (GROUP_ENTRIES),
    .BIN_COUNT     (BIN_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTHESIS
  // Only one word is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is in flight");

  // The sequencer issues at most one command step per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.lookup, cmd.step, cmd.brd, cmd.inc, cmd.emit}))
    else $error("sequencer issued overlapping commands");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
